>>> hw/rtl/lcdv_pkg.sv
`default_nettype none

package lcdv_pkg;

    // Averaging and sample format
    localparam int SAMPLES_PER_AVERAGE = 32;
    localparam int SAMPLE_BITS         = 24;
    localparam int SUM_BITS            = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE);
    localparam int COUNT_BITS          = $clog2(SAMPLES_PER_AVERAGE + 1);

    // Register and result widths
    localparam int GAIN_BITS   = 18;
    localparam int GAIN_FRAC   = 16;
    localparam int THR_BITS    = 26;
    localparam int WEIGHT_BITS = 27;
    localparam int TOTAL_BITS  = 48;
    localparam int TICK_BITS   = 8;
    localparam int DRIVE_BITS  = 4;
    localparam int PHASE_BITS  = 3;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = DIFF_BITS + GAIN_BITS;

    // Stream packing
    localparam int IN_FIELD_BITS  = SAMPLE_BITS + 2;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = DRIVE_BITS + PHASE_BITS + WEIGHT_BITS + TOTAL_BITS + 1;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // APB
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    localparam logic signed [SUM_BITS-1:0] AVG_DIV = SUM_BITS'(SAMPLES_PER_AVERAGE);
    localparam logic [COUNT_BITS-1:0] AVG_COUNT = COUNT_BITS'(SAMPLES_PER_AVERAGE);

    localparam logic signed [TOTAL_BITS-1:0] TOTAL_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
    localparam logic signed [TOTAL_BITS-1:0] TOTAL_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_CAL_GAIN      = 3'd0,
        REG_FULL_THR      = 3'd1,
        REG_NEG_LIMIT     = 3'd2,
        REG_BYPASS_TICKS  = 3'd3,
        REG_MOTOR_TICKS   = 3'd4,
        REG_DRAIN_TICKS   = 3'd5,
        REG_CLOSE_TICKS   = 3'd6,
        REG_SETTLE_TICKS  = 3'd7
    } cfg_reg_t;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_BYPASS_OPEN  = 3'd0,
        PH_MOTOR_OPEN   = 3'd1,
        PH_DRAIN_OPEN   = 3'd2,
        PH_BYPASS_CLOSE = 3'd3,
        PH_MOTOR_CLOSE  = 3'd4,
        PH_SETTLE       = 3'd5,
        PH_ZEROING      = 3'd6,
        PH_WEIGHING     = 3'd7
    } phase_t;

    // H-bridge codes: bit0 A1, bit1 A2, bit2 B1, bit3 B2
    localparam logic [DRIVE_BITS-1:0] DRIVE_OFF          = 4'h0;
    localparam logic [DRIVE_BITS-1:0] DRIVE_BYPASS_OPEN  = 4'hA;
    localparam logic [DRIVE_BITS-1:0] DRIVE_MOTOR_OPEN   = 4'h2;
    localparam logic [DRIVE_BITS-1:0] DRIVE_BYPASS_CLOSE = 4'h5;
    localparam logic [DRIVE_BITS-1:0] DRIVE_MOTOR_CLOSE  = 4'h1;

    // Register reset values
    localparam logic [GAIN_BITS-1:0]          RST_CAL_GAIN  = 18'd132665;
    localparam logic [THR_BITS-1:0]           RST_FULL_THR  = 26'd130000;
    localparam logic signed [WEIGHT_BITS-1:0] RST_NEG_LIMIT = -27'sd2000;
    localparam logic [TICK_BITS-1:0]          RST_BYPASS    = 8'd20;
    localparam logic [TICK_BITS-1:0]          RST_MOTOR     = 8'd10;
    localparam logic [TICK_BITS-1:0]          RST_DRAIN     = 8'd50;
    localparam logic [TICK_BITS-1:0]          RST_CLOSE     = 8'd30;
    localparam logic [TICK_BITS-1:0]          RST_SETTLE    = 8'd10;

    typedef struct packed {
        logic [GAIN_BITS-1:0]          cal_gain;
        logic [THR_BITS-1:0]           full_threshold;
        logic signed [WEIGHT_BITS-1:0] negative_limit;
        logic [TICK_BITS-1:0]          bypass_ticks;
        logic [TICK_BITS-1:0]          motor_on_ticks;
        logic [TICK_BITS-1:0]          drain_open_ticks;
        logic [TICK_BITS-1:0]          close_ticks;
        logic [TICK_BITS-1:0]          settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] avg;
        logic signed [WEIGHT_BITS-1:0] weight;
        logic                          over_full;
        logic                          under_limit;
    } scale_t;

endpackage

`default_nettype wire

>>> hw/rtl/lcdv_cfg.sv
`default_nettype none

module lcdv_cfg
    import lcdv_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic      [CFG_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output cfg_t                          cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_reg_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_CAL_GAIN:     cfg_next.cal_gain         = pwdata[GAIN_BITS-1:0];
                REG_FULL_THR:     cfg_next.full_threshold   = pwdata[THR_BITS-1:0];
                REG_NEG_LIMIT:    cfg_next.negative_limit   = $signed(pwdata[WEIGHT_BITS-1:0]);
                REG_BYPASS_TICKS: cfg_next.bypass_ticks     = pwdata[TICK_BITS-1:0];
                REG_MOTOR_TICKS:  cfg_next.motor_on_ticks   = pwdata[TICK_BITS-1:0];
                REG_DRAIN_TICKS:  cfg_next.drain_open_ticks = pwdata[TICK_BITS-1:0];
                REG_CLOSE_TICKS:  cfg_next.close_ticks      = pwdata[TICK_BITS-1:0];
                REG_SETTLE_TICKS: cfg_next.settle_ticks     = pwdata[TICK_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_CAL_GAIN:     prdata = CFG_DATA_BITS'(cfg_reg.cal_gain);
            REG_FULL_THR:     prdata = CFG_DATA_BITS'(cfg_reg.full_threshold);
            REG_NEG_LIMIT:    prdata = CFG_DATA_BITS'(cfg_reg.negative_limit);
            REG_BYPASS_TICKS: prdata = CFG_DATA_BITS'(cfg_reg.bypass_ticks);
            REG_MOTOR_TICKS:  prdata = CFG_DATA_BITS'(cfg_reg.motor_on_ticks);
            REG_DRAIN_TICKS:  prdata = CFG_DATA_BITS'(cfg_reg.drain_open_ticks);
            REG_CLOSE_TICKS:  prdata = CFG_DATA_BITS'(cfg_reg.close_ticks);
            REG_SETTLE_TICKS: prdata = CFG_DATA_BITS'(cfg_reg.settle_ticks);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_gain         <= RST_CAL_GAIN;
            cfg_reg.full_threshold   <= RST_FULL_THR;
            cfg_reg.negative_limit   <= RST_NEG_LIMIT;
            cfg_reg.bypass_ticks     <= RST_BYPASS;
            cfg_reg.motor_on_ticks   <= RST_MOTOR;
            cfg_reg.drain_open_ticks <= RST_DRAIN;
            cfg_reg.close_ticks      <= RST_CLOSE;
            cfg_reg.settle_ticks     <= RST_SETTLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lcdv_scale.sv
`default_nettype none

// Average, offset removal and Q2.16 gain for one completed sample window.
module lcdv_scale
    import lcdv_pkg::*;
(
    input  cfg_t                          cfg,
    input  wire logic signed [SUM_BITS-1:0]    sum,
    input  wire logic signed [SAMPLE_BITS-1:0] offset,
    output scale_t                        res
);

    logic signed [SUM_BITS-1:0]    quot;
    logic signed [SAMPLE_BITS-1:0] avg;
    logic signed [DIFF_BITS-1:0]   diff;
    logic        [DIFF_BITS-1:0]   mag;
    logic        [PROD_BITS-1:0]   prod;
    logic        [WEIGHT_BITS-1:0] mag_w;
    logic signed [WEIGHT_BITS-1:0] weight;

    // signed divide by a power of two: truncates toward zero
    assign quot = sum / AVG_DIV;
    assign avg  = quot[SAMPLE_BITS-1:0];
    assign diff = DIFF_BITS'(avg) - DIFF_BITS'(offset);
    assign mag  = diff[DIFF_BITS-1] ? $unsigned(-diff) : $unsigned(diff);
    assign prod = PROD_BITS'(mag) * PROD_BITS'(cfg.cal_gain);
    assign mag_w = prod[GAIN_FRAC +: WEIGHT_BITS];
    assign weight = diff[DIFF_BITS-1] ? -$signed(mag_w) : $signed(mag_w);

    assign res.avg         = avg;
    assign res.weight      = weight;
    assign res.over_full   = $signed({weight[WEIGHT_BITS-1], weight})
                             > $signed({2'b00, cfg.full_threshold});
    assign res.under_limit = weight < cfg.negative_limit;

endmodule

`default_nettype wire

>>> hw/rtl/lcdv_seq.sv
`default_nettype none

// Phase sequencer, averaging state and result register.
module lcdv_seq
    import lcdv_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  cfg_t                               cfg,
    input  wire logic                          advance,
    input  wire logic                          out_ready,
    input  wire logic                          in_sample_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
    input  wire logic                          in_sync,
    input  wire logic                          in_zero_req,
    output logic                               out_valid,
    output logic [DRIVE_BITS-1:0]              valve_drive,
    output logic [PHASE_BITS-1:0]              phase,
    output logic signed [WEIGHT_BITS-1:0]      weight_out,
    output logic                               weight_valid,
    output logic signed [TOTAL_BITS-1:0]       total_weight,
    output logic                               may_sleep
);

    phase_t                        phase_reg, phase_next, ph_cur;
    logic [TICK_BITS-1:0]          timer_reg, timer_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next, count_inc;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next, sum_add;
    logic signed [SAMPLE_BITS-1:0] offset_reg, offset_next;
    logic signed [WEIGHT_BITS-1:0] weight_reg, weight_next;
    logic signed [TOTAL_BITS-1:0]  total_reg, total_next, total_sat;
    logic [DRIVE_BITS-1:0]         drive_reg, drive_next;
    logic                          pending_reg, pending_next, pend_cur;
    logic                          wv_reg, wv_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          act;
    logic                          take;
    logic                          win_done;
    logic                          drain;
    logic                          timed;
    logic [DRIVE_BITS-1:0]         drive_code;
    logic [TICK_BITS-1:0]          load_ticks;
    logic signed [TOTAL_BITS:0]    total_wide;
    scale_t                        res;

    // sync takes effect before the phase acts
    assign ph_cur   = in_sync ? PH_BYPASS_OPEN : phase_reg;
    assign act      = advance && (timer_reg == '0);
    assign take     = in_sample_valid && (ph_cur == PH_ZEROING || ph_cur == PH_WEIGHING);
    assign sum_add  = sum_reg + SUM_BITS'(in_sample);
    assign count_inc = count_reg + 1'b1;
    assign win_done = count_inc >= AVG_COUNT;
    assign pend_cur = pending_reg || in_zero_req;
    assign drain    = res.over_full || pend_cur;

    lcdv_scale u_scale (
        .cfg    (cfg),
        .sum    (sum_add),
        .offset (offset_reg),
        .res    (res)
    );

    // saturating accumulate of the drained weight
    assign total_wide = TOTAL_BITS'(0) + (TOTAL_BITS+1)'(total_reg) + (TOTAL_BITS+1)'(res.weight);
    always_comb
    begin
        if (total_wide[TOTAL_BITS] != total_wide[TOTAL_BITS-1])
            total_sat = total_wide[TOTAL_BITS] ? TOTAL_MIN : TOTAL_MAX;
        else
            total_sat = total_wide[TOTAL_BITS-1:0];
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            phase_next = ph_cur;
            if (act)
            begin
                unique case (ph_cur)
                    PH_BYPASS_OPEN:  phase_next = PH_MOTOR_OPEN;
                    PH_MOTOR_OPEN:   phase_next = PH_DRAIN_OPEN;
                    PH_DRAIN_OPEN:   phase_next = PH_BYPASS_CLOSE;
                    PH_BYPASS_CLOSE: phase_next = PH_MOTOR_CLOSE;
                    PH_MOTOR_CLOSE:  phase_next = PH_SETTLE;
                    PH_SETTLE:       phase_next = PH_ZEROING;
                    PH_ZEROING:
                        if (take && win_done)
                            phase_next = PH_WEIGHING;
                    PH_WEIGHING:
                        if (take && win_done)
                        begin
                            if (res.under_limit)
                                phase_next = PH_ZEROING;
                            else if (drain)
                                phase_next = PH_BYPASS_OPEN;
                        end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // per-phase drive code and dwell
    always_comb
    begin
        timed      = 1'b1;
        drive_code = DRIVE_OFF;
        load_ticks = '0;
        unique case (ph_cur)
            PH_BYPASS_OPEN:
            begin
                drive_code = DRIVE_BYPASS_OPEN;
                load_ticks = cfg.bypass_ticks;
            end
            PH_MOTOR_OPEN:
            begin
                drive_code = DRIVE_MOTOR_OPEN;
                load_ticks = cfg.motor_on_ticks;
            end
            PH_DRAIN_OPEN:
            begin
                drive_code = DRIVE_OFF;
                load_ticks = cfg.drain_open_ticks;
            end
            PH_BYPASS_CLOSE:
            begin
                drive_code = DRIVE_BYPASS_CLOSE;
                load_ticks = cfg.bypass_ticks;
            end
            PH_MOTOR_CLOSE:
            begin
                drive_code = DRIVE_MOTOR_CLOSE;
                load_ticks = cfg.close_ticks;
            end
            PH_SETTLE:
            begin
                drive_code = DRIVE_OFF;
                load_ticks = cfg.settle_ticks;
            end
            default:
                timed = 1'b0;
        endcase
    end

    // datapath state
    always_comb
    begin
        timer_next   = timer_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        offset_next  = offset_reg;
        weight_next  = weight_reg;
        total_next   = total_reg;
        drive_next   = drive_reg;
        pending_next = pending_reg;
        wv_next      = wv_reg;

        if (advance)
        begin
            pending_next = pend_cur;
            wv_next      = 1'b0;
            if (in_sync)
                total_next = '0;

            if (timer_reg != '0)
            begin
                timer_next = timer_reg - 1'b1;
            end
            else if (timed)
            begin
                drive_next = drive_code;
                timer_next = load_ticks;
                if (ph_cur == PH_SETTLE)
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
            end
            else if (take)
            begin
                sum_next   = sum_add;
                count_next = count_inc;
                if (win_done)
                begin
                    count_next = '0;
                    sum_next   = '0;
                    if (ph_cur == PH_ZEROING)
                    begin
                        offset_next = res.avg;
                    end
                    else
                    begin
                        weight_next = res.weight;
                        wv_next     = 1'b1;
                        if (drain)
                        begin
                            total_next   = total_sat;
                            weight_next  = '0;
                            pending_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BYPASS_OPEN;
            timer_reg     <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            offset_reg    <= '0;
            weight_reg    <= '0;
            total_reg     <= '0;
            drive_reg     <= DRIVE_OFF;
            pending_reg   <= 1'b0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            offset_reg    <= offset_next;
            weight_reg    <= weight_next;
            total_reg     <= total_next;
            drive_reg     <= drive_next;
            pending_reg   <= pending_next;
            wv_reg        <= wv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // state registers double as the result register
    assign out_valid    = out_valid_reg;
    assign valve_drive  = drive_reg;
    assign phase        = phase_reg;
    assign weight_out   = weight_reg;
    assign weight_valid = wv_reg;
    assign total_weight = total_reg;
    assign may_sleep    = (phase_reg == PH_WEIGHING);

`ifndef NO_ASSERTIONS
    a_wv_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && wv_reg |-> phase_reg == PH_BYPASS_OPEN
            || phase_reg == PH_ZEROING || phase_reg == PH_WEIGHING)
        else $error("weighing result outside a weighing exit phase");

    a_sync_total: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_sync |=> total_reg == '0)
        else $error("sync did not clear the total");

    a_timer_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && timer_reg != '0 && !in_sync |=> phase_reg == $past(phase_reg)
            && timer_reg == $past(timer_reg) - 1'b1)
        else $error("phase moved while the dwell timer ran");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/load_cell_drain_valve_sequencer.sv
// Load-cell drain-valve sequencer. Each request on the input stream is one
// tick and yields exactly one result carrying the valve drive, the phase, the
// last calibrated weight, a weighing-done flag, the saturating drained total
// and a sleep hint. A tick is registered on entry, then the whole phase update
// (timer, valve decode, 32-sample average, offset removal, one 25x18 gain
// multiply, threshold compares, 48-bit saturating add) runs in one combinational
// pass into the state registers, which double as the result register. Throughput
// is one request per clock while results are taken; a result not taken holds
// the next request in the input register, but does not block a request from
// entering it while it is empty. Configure over APB only while the stream is
// idle; registers sit at byte offsets 4*i, reads return the value.
`default_nettype none

module load_cell_drain_valve_sequencer
    import lcdv_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // [23:0] sample, [24] sync_command, [25] zero_request, rest zero
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
    // [0] sample_valid
    input  wire logic                     s_tuser,

    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [3:0] valve_drive, [6:4] phase, [33:7] weight_out,
    // [81:34] total_weight, [82] may_sleep, rest zero
    output logic [OUT_DATA_BITS-1:0]      m_tdata,
    // [0] weight_valid
    output logic                          m_tuser,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic      [CFG_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    cfg_t cfg;

    // input register
    logic                          in_valid_reg, in_valid_next;
    logic                          in_svalid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_sync_reg;
    logic                          in_zero_reg;

    logic s_accept;
    logic advance;
    logic out_valid;

    logic [DRIVE_BITS-1:0]         valve_drive;
    logic [PHASE_BITS-1:0]         phase;
    logic signed [WEIGHT_BITS-1:0] weight_out;
    logic                          weight_valid;
    logic signed [TOTAL_BITS-1:0]  total_weight;
    logic                          may_sleep;

    // request moves into the sequencer when the result slot is free or drains
    assign advance  = in_valid_reg && (!out_valid || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_svalid_reg <= s_tuser;
            in_sample_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            in_sync_reg   <= s_tdata[SAMPLE_BITS];
            in_zero_reg   <= s_tdata[SAMPLE_BITS+1];
        end
    end

    lcdv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcdv_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .advance         (advance),
        .out_ready       (m_tready),
        .in_sample_valid (in_svalid_reg),
        .in_sample       (in_sample_reg),
        .in_sync         (in_sync_reg),
        .in_zero_req     (in_zero_reg),
        .out_valid       (out_valid),
        .valve_drive     (valve_drive),
        .phase           (phase),
        .weight_out      (weight_out),
        .weight_valid    (weight_valid),
        .total_weight    (total_weight),
        .may_sleep       (may_sleep)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = weight_valid;
    assign m_tdata  = OUT_DATA_BITS'({may_sleep, total_weight, weight_out, phase, valve_drive});

endmodule

`default_nettype wire
